// ----- rtl/core/atc_pkg.sv -----
// Shared constants, codes and types of the ATA task-file command issuer.
package atc_pkg;

   // Field and register widths.
   localparam int unsigned LBA_W       = 48;
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned CYL_W       = 16;
   localparam int unsigned HEADS_W     = 5;
   localparam int unsigned SPT_W       = 6;
   localparam int unsigned MAX28_W     = 28;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 48;

   // Default depth of the command queue between front and back.
   localparam int unsigned QUEUE_DEPTH = 2;

   // CHS divider: dividend below cylinder_count * heads * spt, divisor heads * spt.
   localparam int unsigned CHS_NUM_W   = 27;
   localparam int unsigned CHS_DIV_W   = 11;
   localparam int unsigned DIV_STEP_W  = 5;

   // Addressing modes.
   localparam logic [1:0] MODE_CHS      = 2'd0;
   localparam logic [1:0] MODE_LBA28    = 2'd1;
   localparam logic [1:0] MODE_LBA48    = 2'd2;
   localparam logic [1:0] MODE_RESERVED = 2'd3;

   // Result status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_RANGE   = 2'd1;
   localparam logic [1:0] STATUS_COUNT   = 2'd2;
   localparam logic [1:0] STATUS_DMA_CHS = 2'd3;

   // Command block register offsets.
   localparam logic [2:0] ATA_REG_DATA    = 3'd0;
   localparam logic [2:0] ATA_REG_COUNT   = 3'd2;
   localparam logic [2:0] ATA_REG_DEVICE  = 3'd6;
   localparam logic [2:0] ATA_REG_COMMAND = 3'd7;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESSING_MODE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CYLINDER_COUNT    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_COUNT        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECTORS_PER_TRACK = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LBA28         = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LBA48         = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_SELECT      = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_DMA           = 3'd7;

   // Selector bytes and limits.
   localparam logic [7:0]         SEL_CHS_BASE    = 8'hA0;
   localparam logic [7:0]         SEL_LBA_BASE    = 8'hE0;
   localparam logic [7:0]         SEL_NONE        = 8'hFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX_SHORT = 16'h00FF;

   // Opcodes.
   localparam logic [7:0] OP_PIO_READ        = 8'h20;
   localparam logic [7:0] OP_PIO_WRITE       = 8'h30;
   localparam logic [7:0] OP_PIO_READ_EXT    = 8'h24;
   localparam logic [7:0] OP_PIO_WRITE_EXT   = 8'h34;
   localparam logic [7:0] OP_DMA_READ        = 8'hC8;
   localparam logic [7:0] OP_DMA_WRITE       = 8'hCA;
   localparam logic [7:0] OP_DMA_READ_EXT    = 8'h25;
   localparam logic [7:0] OP_DMA_WRITE_EXT   = 8'h35;

   // Reset values of the configuration registers.
   localparam logic [1:0]         RESET_MODE      = MODE_LBA28;
   localparam logic [CYL_W-1:0]   RESET_CYLINDERS = 16'd1024;
   localparam logic [HEADS_W-1:0] RESET_HEADS     = 5'd16;
   localparam logic [SPT_W-1:0]   RESET_SPT       = 6'd63;

   // Configuration register set.
   typedef struct packed {
      logic [1:0]         addressing_mode;
      logic [CYL_W-1:0]   cylinder_count;
      logic [HEADS_W-1:0] head_count;
      logic [SPT_W-1:0]   sectors_per_track;
      logic [MAX28_W-1:0] max_lba28;
      logic [LBA_W-1:0]   max_lba48;
      logic               drive_select;
      logic               use_dma;
   } cfg_type;

   // Classified command passed from front to back.
   typedef struct packed {
      logic [1:0]         status;
      logic               write;
      logic [1:0]         mode;
      logic               use_dma;
      logic               drive;
      logic [COUNT_W-1:0] count;
      logic [LBA_W-1:0]   lba;
      logic [CYL_W-1:0]   cyl;
      logic [3:0]         head;
      logic [SPT_W-1:0]   sector;
   } cmd_type;

   // Divider request and response.
   typedef struct packed {
      logic                  start;
      logic [DIV_STEP_W-1:0] steps;
      logic [CHS_NUM_W-1:0]  dividend;
      logic [CHS_DIV_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [CHS_NUM_W-1:0] quotient;
      logic [CHS_DIV_W-1:0] remainder;
   } div_rsp_type;

   // One register write result.
   typedef struct packed {
      logic [2:0] reg_offset;
      logic [7:0] reg_value;
      logic [1:0] status;
      logic       last;
   } rsp_type;

endpackage

// ----- rtl/core/ata_taskfile_command_issuer.sv -----
// Top level of the ATA task-file command issuer: configuration registers and the two ends.
//
// Each accepted request (direction, start sector, sector count) yields the ordered
// command-block register writes that start it: the drive/head selector (left out when
// it equals the last one written), the count and address bytes (CHS, LBA28, or two
// LBA48 waves with the high bytes first) and finally the opcode, the final write
// flagged by rsp_last. A request that cannot be issued yields one result with a
// nonzero status and writes nothing. The front end checks each request; in CHS mode it
// also bounds the end address and runs the one-bit-per-cycle shift-subtract divider
// twice to split the start sector into cylinder, head and sector. The back end takes
// each command through a start state and then emits its writes in order, holding while
// the output register is full; a two-entry command queue lets both ends run at once.
// Configuration registers take effect for requests accepted after the write and
// should be written only while no request is in flight.
module ata_taskfile_command_issuer #(
   parameter int unsigned QUEUE_DEPTH = atc_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic                            req_kind,
   input  logic [atc_pkg::LBA_W-1:0]       req_start_sector,
   input  logic [atc_pkg::COUNT_W-1:0]     req_sector_count,
   output logic                            empty,
   input  logic                            pop,
   output logic [2:0]                      rsp_reg_offset,
   output logic [7:0]                      rsp_reg_value,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_last,
   input  logic                            csr_write,
   input  logic [atc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [atc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   atc_pkg::cfg_type cfg_ff, cfg_in;
   logic             q_push;
   logic             q_full;
   logic             q_pop;
   logic             q_empty;
   atc_pkg::cmd_type q_wdata;
   atc_pkg::cmd_type q_rdata;
   atc_pkg::rsp_type rsp;

   // Configuration register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            atc_pkg::CSR_ADDRESSING_MODE:   cfg_in.addressing_mode   = csr_wdata[1:0];
            atc_pkg::CSR_CYLINDER_COUNT:    cfg_in.cylinder_count    =
                                               csr_wdata[atc_pkg::CYL_W-1:0];
            atc_pkg::CSR_HEAD_COUNT:        cfg_in.head_count        =
                                               csr_wdata[atc_pkg::HEADS_W-1:0];
            atc_pkg::CSR_SECTORS_PER_TRACK: cfg_in.sectors_per_track =
                                               csr_wdata[atc_pkg::SPT_W-1:0];
            atc_pkg::CSR_MAX_LBA28:         cfg_in.max_lba28         =
                                               csr_wdata[atc_pkg::MAX28_W-1:0];
            atc_pkg::CSR_MAX_LBA48:         cfg_in.max_lba48         =
                                               csr_wdata[atc_pkg::LBA_W-1:0];
            atc_pkg::CSR_DRIVE_SELECT:      cfg_in.drive_select      = csr_wdata[0];
            atc_pkg::CSR_USE_DMA:           cfg_in.use_dma           = csr_wdata[0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.addressing_mode   <= atc_pkg::RESET_MODE;
         cfg_ff.cylinder_count    <= atc_pkg::RESET_CYLINDERS;
         cfg_ff.head_count        <= atc_pkg::RESET_HEADS;
         cfg_ff.sectors_per_track <= atc_pkg::RESET_SPT;
         cfg_ff.max_lba28         <= '0;
         cfg_ff.max_lba48         <= '0;
         cfg_ff.drive_select      <= 1'b0;
         cfg_ff.use_dma           <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   atc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .push             (push),
      .full             (full),
      .req_kind         (req_kind),
      .req_start_sector (req_start_sector),
      .req_sector_count (req_sector_count),
      .q_push           (q_push),
      .q_data           (q_wdata),
      .q_full           (q_full)
   );

   atc_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_rdata (q_rdata),
      .q_empty (q_empty)
   );

   atc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_rdata (q_rdata),
      .q_pop   (q_pop),
      .empty   (empty),
      .pop     (pop),
      .rsp     (rsp)
   );

   assign rsp_reg_offset = rsp.reg_offset;
   assign rsp_reg_value  = rsp.reg_value;
   assign rsp_status     = rsp.status;
   assign rsp_last       = rsp.last;

endmodule

// ----- rtl/core/atc_divider.sv -----
// Shift-subtract divider, one quotient bit per cycle, used for the CHS conversion.
module atc_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  atc_pkg::div_req_type div_req,
   output atc_pkg::div_rsp_type div_rsp
);

   localparam int unsigned NUM_W  = atc_pkg::CHS_NUM_W;
   localparam int unsigned DIV_W  = atc_pkg::CHS_DIV_W;
   localparam int unsigned STEP_W = atc_pkg::DIV_STEP_W;

   logic [NUM_W-1:0]  num_ff, num_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  divisor_ff, divisor_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    diff;
   logic              fits;

   // Partial remainder with the next dividend bit brought down.
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   // Load on start, then one restoring step per cycle.
   always_comb begin
      num_in     = num_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         num_in     = div_req.dividend;
         quo_in     = '0;
         rem_in     = '0;
         divisor_in = div_req.divisor;
         count_in   = div_req.steps;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         num_in   = {num_ff[NUM_W-2:0], 1'b0};
         quo_in   = {quo_ff[NUM_W-2:0], fits};
         rem_in   = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         count_in = count_ff - STEP_W'(1);
         if (count_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff     <= num_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      count_ff   <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ----- rtl/core/atc_front.sv -----
// Front end: accepts requests, checks them and works out the CHS address.
module atc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  atc_pkg::cfg_type            cfg,
   input  logic                        push,
   output logic                        full,
   input  logic                        req_kind,
   input  logic [atc_pkg::LBA_W-1:0]   req_start_sector,
   input  logic [atc_pkg::COUNT_W-1:0] req_sector_count,
   output logic                        q_push,
   output atc_pkg::cmd_type            q_data,
   input  logic                        q_full
);

   localparam int unsigned NUM_W  = atc_pkg::CHS_NUM_W;
   localparam int unsigned DIV_W  = atc_pkg::CHS_DIV_W;
   localparam int unsigned END_W  = atc_pkg::LBA_W + 1;
   localparam int unsigned STEP_W = atc_pkg::DIV_STEP_W;
   localparam int unsigned SPT_W  = atc_pkg::SPT_W;

   typedef enum logic [2:0] {
      F_IDLE,
      F_CHECK,
      F_LIMIT,
      F_DIV_CYL,
      F_DIV_HEAD,
      F_PUSH
   } state_type;

   state_type            state_ff, state_in;
   atc_pkg::cmd_type     cmd_ff, cmd_in;
   logic [END_W-1:0]     end_ff, end_in;
   logic [DIV_W-1:0]     hpc_ff, hpc_in;
   logic [NUM_W-1:0]     limit_ff, limit_in;
   logic [NUM_W-1:0]     limit_prod;
   atc_pkg::div_req_type div_req;
   atc_pkg::div_rsp_type div_rsp;

   atc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Sectors per cylinder times cylinders bounds the CHS end address.
   assign limit_prod = NUM_W'(cfg.cylinder_count) * NUM_W'(hpc_ff);

   // Request classification sequencer.
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      end_in   = end_ff;
      hpc_in   = hpc_ff;
      limit_in = limit_ff;
      q_push   = 1'b0;
      div_req  = '0;
      unique case (state_ff)
         F_IDLE: begin
            if (push) begin
               cmd_in.status  = atc_pkg::STATUS_OK;
               cmd_in.write   = req_kind;
               cmd_in.mode    = cfg.addressing_mode;
               cmd_in.use_dma = cfg.use_dma;
               cmd_in.drive   = cfg.drive_select;
               cmd_in.count   = req_sector_count;
               cmd_in.lba     = req_start_sector;
               cmd_in.cyl     = '0;
               cmd_in.head    = '0;
               cmd_in.sector  = '0;
               end_in   = END_W'(req_start_sector) + END_W'(req_sector_count);
               hpc_in   = DIV_W'(cfg.head_count) * DIV_W'(cfg.sectors_per_track);
               state_in = F_CHECK;
            end
         end
         F_CHECK: begin
            state_in = F_PUSH;
            if (cmd_ff.mode == atc_pkg::MODE_RESERVED) begin
               cmd_in.status = atc_pkg::STATUS_RANGE;
            end else if (cmd_ff.mode == atc_pkg::MODE_CHS && cmd_ff.use_dma) begin
               cmd_in.status = atc_pkg::STATUS_DMA_CHS;
            end else if (cmd_ff.mode != atc_pkg::MODE_LBA48 &&
                         cmd_ff.count > atc_pkg::COUNT_MAX_SHORT) begin
               cmd_in.status = atc_pkg::STATUS_COUNT;
            end else if (cmd_ff.mode == atc_pkg::MODE_LBA28) begin
               if (end_ff >= END_W'(cfg.max_lba28)) begin
                  cmd_in.status = atc_pkg::STATUS_RANGE;
               end
            end else if (cmd_ff.mode == atc_pkg::MODE_LBA48) begin
               if (end_ff >= END_W'(cfg.max_lba48)) begin
                  cmd_in.status = atc_pkg::STATUS_RANGE;
               end
            end else if (hpc_ff == '0) begin
               cmd_in.status = atc_pkg::STATUS_RANGE;
            end else begin
               limit_in = limit_prod;
               state_in = F_LIMIT;
            end
         end
         F_LIMIT: begin
            // An end past the last cylinder is refused; in range, the start address fits the divider.
            if (end_ff >= END_W'(limit_ff)) begin
               cmd_in.status = atc_pkg::STATUS_RANGE;
               state_in      = F_PUSH;
            end else begin
               div_req.start    = 1'b1;
               div_req.steps    = STEP_W'(NUM_W);
               div_req.dividend = cmd_ff.lba[NUM_W-1:0];
               div_req.divisor  = hpc_ff;
               state_in         = F_DIV_CYL;
            end
         end
         F_DIV_CYL: begin
            // Cylinder is the quotient; the remainder splits into head and sector.
            if (div_rsp.done) begin
               cmd_in.cyl       = div_rsp.quotient[atc_pkg::CYL_W-1:0];
               div_req.start    = 1'b1;
               div_req.steps    = STEP_W'(DIV_W);
               div_req.dividend = {div_rsp.remainder, {(NUM_W-DIV_W){1'b0}}};
               div_req.divisor  = DIV_W'(cfg.sectors_per_track);
               state_in         = F_DIV_HEAD;
            end
         end
         F_DIV_HEAD: begin
            if (div_rsp.done) begin
               cmd_in.head   = div_rsp.quotient[3:0];
               cmd_in.sector = div_rsp.remainder[SPT_W-1:0] + SPT_W'(1);
               state_in      = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      end_ff   <= end_in;
      hpc_ff   <= hpc_in;
      limit_ff <= limit_in;
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign full   = (state_ff != F_IDLE);
   assign q_data = cmd_ff;

   // The divider only finishes while the front waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == F_DIV_CYL || state_ff == F_DIV_HEAD))
      else $error("divider finished outside a divide state");

endmodule

// ----- rtl/core/atc_cmd_queue.sv -----
// Short queue of classified commands between the front and back ends.
module atc_cmd_queue #(
   parameter int unsigned DEPTH = atc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_push,
   input  atc_pkg::cmd_type q_wdata,
   output logic             q_full,
   input  logic             q_pop,
   output atc_pkg::cmd_type q_rdata,
   output logic             q_empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   atc_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign q_full  = (count_ff == CNT_W'(DEPTH));
   assign q_empty = (count_ff == '0);
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && !q_empty;
   assign q_rdata = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_wdata;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // The front never offers a command while the queue is full.
   assert property (@(posedge clock) disable iff (reset) !(q_push && q_full))
      else $error("command pushed into a full queue");

   // The fill count never passes the depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("command queue count overflow");

endmodule

// ----- rtl/core/atc_back.sv -----
// Back end: turns each classified command into its ordered register writes.
module atc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  atc_pkg::cmd_type q_rdata,
   output logic             q_pop,
   output logic             empty,
   input  logic             pop,
   output atc_pkg::rsp_type rsp
);

   typedef enum logic [2:0] {
      B_IDLE,
      B_START,
      B_ERROR,
      B_SELECT,
      B_HIGH,
      B_LOW,
      B_COMMAND
   } state_type;

   state_type        state_ff, state_in;
   atc_pkg::cmd_type cmd_ff, cmd_in;
   logic [1:0]       idx_ff, idx_in;
   logic [7:0]       sel_ff, sel_in;
   logic             sel_valid_ff, sel_valid_in;
   logic             out_valid_ff, out_valid_in;
   atc_pkg::rsp_type out_ff, out_in;
   logic             can_load;
   logic [7:0]       selector;
   logic [7:0]       high_byte;
   logic [7:0]       low_byte;
   logic [7:0]       opcode;
   logic [2:0]       addr_offset;

   // The output register takes a new write when free or being drained.
   assign can_load    = !out_valid_ff || pop;
   assign addr_offset = atc_pkg::ATA_REG_COUNT + {1'b0, idx_ff};

   // Drive/head selector byte for this command.
   always_comb begin
      unique case (cmd_ff.mode)
         atc_pkg::MODE_CHS: begin
            selector = atc_pkg::SEL_CHS_BASE | {3'b000, cmd_ff.drive, cmd_ff.head};
         end
         atc_pkg::MODE_LBA28: begin
            selector = atc_pkg::SEL_LBA_BASE | {3'b000, cmd_ff.drive, cmd_ff.lba[27:24]};
         end
         default: begin
            selector = atc_pkg::SEL_LBA_BASE | {3'b000, cmd_ff.drive, 4'h0};
         end
      endcase
   end

   // Previous-content bytes of the 48-bit wave.
   always_comb begin
      case (idx_ff)
         2'd0:    high_byte = cmd_ff.count[15:8];
         2'd1:    high_byte = cmd_ff.lba[31:24];
         2'd2:    high_byte = cmd_ff.lba[39:32];
         default: high_byte = cmd_ff.lba[47:40];
      endcase
   end

   // Current-content bytes: count and address, CHS or LBA.
   always_comb begin
      case (idx_ff)
         2'd0: low_byte = cmd_ff.count[7:0];
         2'd1: begin
            low_byte = (cmd_ff.mode == atc_pkg::MODE_CHS) ?
                       {2'b00, cmd_ff.sector} : cmd_ff.lba[7:0];
         end
         2'd2: begin
            low_byte = (cmd_ff.mode == atc_pkg::MODE_CHS) ?
                       cmd_ff.cyl[7:0] : cmd_ff.lba[15:8];
         end
         default: begin
            low_byte = (cmd_ff.mode == atc_pkg::MODE_CHS) ?
                       cmd_ff.cyl[15:8] : cmd_ff.lba[23:16];
         end
      endcase
   end

   // Opcode by transfer type, address width and direction.
   always_comb begin
      if (cmd_ff.use_dma) begin
         if (cmd_ff.mode == atc_pkg::MODE_LBA48) begin
            opcode = cmd_ff.write ? atc_pkg::OP_DMA_WRITE_EXT : atc_pkg::OP_DMA_READ_EXT;
         end else begin
            opcode = cmd_ff.write ? atc_pkg::OP_DMA_WRITE : atc_pkg::OP_DMA_READ;
         end
      end else begin
         if (cmd_ff.mode == atc_pkg::MODE_LBA48) begin
            opcode = cmd_ff.write ? atc_pkg::OP_PIO_WRITE_EXT : atc_pkg::OP_PIO_READ_EXT;
         end else begin
            opcode = cmd_ff.write ? atc_pkg::OP_PIO_WRITE : atc_pkg::OP_PIO_READ;
         end
      end
   end

   // Write sequencer.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      sel_in       = sel_ff;
      sel_valid_in = sel_valid_ff;
      out_valid_in = out_valid_ff && !pop;
      out_in       = out_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_rdata;
               state_in = B_START;
            end
         end
         B_START: begin
            idx_in = '0;
            if (cmd_ff.status != atc_pkg::STATUS_OK) begin
               state_in = B_ERROR;
            end else if (!sel_valid_ff || sel_ff != selector) begin
               state_in = B_SELECT;
            end else if (cmd_ff.mode == atc_pkg::MODE_LBA48) begin
               state_in = B_HIGH;
            end else begin
               state_in = B_LOW;
            end
         end
         B_ERROR: begin
            if (can_load) begin
               out_valid_in = 1'b1;
               out_in       = '{atc_pkg::ATA_REG_DATA, 8'h00, cmd_ff.status, 1'b1};
               state_in     = B_IDLE;
            end
         end
         B_SELECT: begin
            if (can_load) begin
               out_valid_in = 1'b1;
               out_in       = '{atc_pkg::ATA_REG_DEVICE, selector, atc_pkg::STATUS_OK, 1'b0};
               sel_in       = selector;
               sel_valid_in = 1'b1;
               state_in     = (cmd_ff.mode == atc_pkg::MODE_LBA48) ? B_HIGH : B_LOW;
            end
         end
         B_HIGH: begin
            if (can_load) begin
               out_valid_in = 1'b1;
               out_in       = '{addr_offset, high_byte, atc_pkg::STATUS_OK, 1'b0};
               idx_in       = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  state_in = B_LOW;
               end
            end
         end
         B_LOW: begin
            if (can_load) begin
               out_valid_in = 1'b1;
               out_in       = '{addr_offset, low_byte, atc_pkg::STATUS_OK, 1'b0};
               idx_in       = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  state_in = B_COMMAND;
               end
            end
         end
         B_COMMAND: begin
            if (can_load) begin
               out_valid_in = 1'b1;
               out_in       = '{atc_pkg::ATA_REG_COMMAND, opcode, atc_pkg::STATUS_OK, 1'b1};
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      out_ff <= out_in;
      if (reset) begin
         state_ff     <= B_IDLE;
         sel_ff       <= atc_pkg::SEL_NONE;
         sel_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         sel_valid_ff <= sel_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign empty = !out_valid_ff;
   assign rsp   = out_ff;

   // An error result is always the only, and so the last, write of its request.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status != atc_pkg::STATUS_OK) |-> out_ff.last)
      else $error("error result not marked last");

   // Once a selector has been written it stays known.
   assert property (@(posedge clock) disable iff (reset) sel_valid_ff |=> sel_valid_ff)
      else $error("selector record lost");

   // Selector writes always carry the fixed high bits of the device register.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.reg_offset == atc_pkg::ATA_REG_DEVICE) |->
      (out_ff.reg_value[7] && out_ff.reg_value[5] && out_ff.last == 1'b0))
      else $error("malformed selector write");

endmodule

// ----- test/ata_taskfile_command_issuer_tb.sv -----
// Self-checking testbench for the ATA task-file command issuer.
`timescale 1ns / 100ps

module ata_taskfile_command_issuer_tb;

   // Address byte registers of the command block, and the transfer directions.
   localparam logic [2:0] REG_ADDR_LOW  = 3'd3;
   localparam logic [2:0] REG_ADDR_MID  = 3'd4;
   localparam logic [2:0] REG_ADDR_HIGH = 3'd5;
   localparam logic       XFER_READ     = 1'b0;
   localparam logic       XFER_WRITE    = 1'b1;

   localparam int MAX_REPORTS = 10;
   localparam int QUIET_LIMIT = 2000;

   typedef struct packed {
      logic                        kind;
      logic [atc_pkg::LBA_W-1:0]   start_sector;
      logic [atc_pkg::COUNT_W-1:0] sector_count;
   } xfer_req_type;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            push = 1'b0;
   logic                            full;
   logic                            req_kind = 1'b0;
   logic [atc_pkg::LBA_W-1:0]       req_start_sector = '0;
   logic [atc_pkg::COUNT_W-1:0]     req_sector_count = '0;
   logic                            empty;
   logic                            pop = 1'b0;
   logic [2:0]                      rsp_reg_offset;
   logic [7:0]                      rsp_reg_value;
   logic [1:0]                      rsp_status;
   logic                            rsp_last;
   logic                            csr_write = 1'b0;
   logic [atc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [atc_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // Requests waiting to be sent and register writes still owed by the block.
   xfer_req_type     queued_requests[$];
   atc_pkg::rsp_type pending_writes[$];
   xfer_req_type     req_on_bus;

   // Our own copy of the settings and of the last selector byte written.
   atc_pkg::cfg_type cfg_copy;
   logic [7:0]       device_sel_byte = atc_pkg::SEL_NONE;
   logic             device_sel_known = 1'b0;

   int error_count = 0;
   int quiet_cycles = 0;
   int req_gap = 0;
   int req_calm = 0;
   int rsp_stall = 0;
   int rsp_calm = 0;

   ata_taskfile_command_issuer DUT (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_kind         (req_kind),
      .req_start_sector (req_start_sector),
      .req_sector_count (req_sector_count),
      .empty            (empty),
      .pop              (pop),
      .rsp_reg_offset   (rsp_reg_offset),
      .rsp_reg_value    (rsp_reg_value),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cfg_copy.addressing_mode   = atc_pkg::RESET_MODE;
      cfg_copy.cylinder_count    = atc_pkg::RESET_CYLINDERS;
      cfg_copy.head_count        = atc_pkg::RESET_HEADS;
      cfg_copy.sectors_per_track = atc_pkg::RESET_SPT;
      cfg_copy.max_lba28         = '0;
      cfg_copy.max_lba48         = '0;
      cfg_copy.drive_select      = 1'b0;
      cfg_copy.use_dma           = 1'b1;
   end

   // Idle length for either side: mostly short, now and then long, with calm runs of none.
   function automatic int pick_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      if (roll < 45) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void owe_write(input logic [2:0] offset, input logic [7:0] value,
                                     input logic [1:0] status, input logic last);
      atc_pkg::rsp_type w;
      w.reg_offset = offset;
      w.reg_value  = value;
      w.status     = status;
      w.last       = last;
      pending_writes.push_back(w);
   endfunction

   // Works out the register writes that one request must produce.
   function automatic void derive_taskfile_writes(input xfer_req_type req);
      logic [63:0] first, stop, per_cyl;
      logic [15:0] cyl;
      logic [3:0]  head;
      logic [7:0]  sect, sel, opcode;
      logic [1:0]  mode;
      first = 64'(req.start_sector);
      stop  = first + 64'(req.sector_count);
      mode  = cfg_copy.addressing_mode;
      cyl   = '0;
      head  = '0;
      sect  = '0;
      sel   = '0;

      // Rejections come in a fixed order and leave the selector alone.
      if (mode == atc_pkg::MODE_RESERVED) begin
         owe_write(atc_pkg::ATA_REG_DATA, 8'h00, atc_pkg::STATUS_RANGE, 1'b1);
         return;
      end
      if (mode == atc_pkg::MODE_CHS && cfg_copy.use_dma) begin
         owe_write(atc_pkg::ATA_REG_DATA, 8'h00, atc_pkg::STATUS_DMA_CHS, 1'b1);
         return;
      end
      if (mode != atc_pkg::MODE_LBA48 && req.sector_count > atc_pkg::COUNT_MAX_SHORT) begin
         owe_write(atc_pkg::ATA_REG_DATA, 8'h00, atc_pkg::STATUS_COUNT, 1'b1);
         return;
      end

      // Bounds check and selector byte for each addressing mode.
      case (mode)
         atc_pkg::MODE_CHS: begin
            per_cyl = 64'(cfg_copy.head_count) * 64'(cfg_copy.sectors_per_track);
            if (per_cyl == 64'd0) begin
               owe_write(atc_pkg::ATA_REG_DATA, 8'h00, atc_pkg::STATUS_RANGE, 1'b1);
               return;
            end
            if (stop / per_cyl >= 64'(cfg_copy.cylinder_count)) begin
               owe_write(atc_pkg::ATA_REG_DATA, 8'h00, atc_pkg::STATUS_RANGE, 1'b1);
               return;
            end
            cyl  = 16'(first / per_cyl);
            head = 4'((first / 64'(cfg_copy.sectors_per_track)) % 64'(cfg_copy.head_count));
            sect = 8'(first % 64'(cfg_copy.sectors_per_track) + 64'd1);
            sel  = atc_pkg::SEL_CHS_BASE | {3'b000, cfg_copy.drive_select, head};
         end
         atc_pkg::MODE_LBA28: begin
            if (stop >= 64'(cfg_copy.max_lba28)) begin
               owe_write(atc_pkg::ATA_REG_DATA, 8'h00, atc_pkg::STATUS_RANGE, 1'b1);
               return;
            end
            sel = atc_pkg::SEL_LBA_BASE | {3'b000, cfg_copy.drive_select, first[27:24]};
         end
         default: begin
            if (stop >= 64'(cfg_copy.max_lba48)) begin
               owe_write(atc_pkg::ATA_REG_DATA, 8'h00, atc_pkg::STATUS_RANGE, 1'b1);
               return;
            end
            sel = atc_pkg::SEL_LBA_BASE | {3'b000, cfg_copy.drive_select, 4'b0000};
         end
      endcase

      // The selector is written only when it differs from the one last written.
      if (!device_sel_known || device_sel_byte != sel) begin
         owe_write(atc_pkg::ATA_REG_DEVICE, sel, atc_pkg::STATUS_OK, 1'b0);
         device_sel_byte  = sel;
         device_sel_known = 1'b1;
      end

      // Count and address bytes; LBA48 sends the high wave first.
      if (mode == atc_pkg::MODE_CHS) begin
         owe_write(atc_pkg::ATA_REG_COUNT, req.sector_count[7:0], atc_pkg::STATUS_OK, 1'b0);
         owe_write(REG_ADDR_LOW, sect, atc_pkg::STATUS_OK, 1'b0);
         owe_write(REG_ADDR_MID, cyl[7:0], atc_pkg::STATUS_OK, 1'b0);
         owe_write(REG_ADDR_HIGH, cyl[15:8], atc_pkg::STATUS_OK, 1'b0);
      end else begin
         if (mode == atc_pkg::MODE_LBA48) begin
            owe_write(atc_pkg::ATA_REG_COUNT, req.sector_count[15:8], atc_pkg::STATUS_OK,
                      1'b0);
            owe_write(REG_ADDR_LOW, first[31:24], atc_pkg::STATUS_OK, 1'b0);
            owe_write(REG_ADDR_MID, first[39:32], atc_pkg::STATUS_OK, 1'b0);
            owe_write(REG_ADDR_HIGH, first[47:40], atc_pkg::STATUS_OK, 1'b0);
         end
         owe_write(atc_pkg::ATA_REG_COUNT, req.sector_count[7:0], atc_pkg::STATUS_OK, 1'b0);
         owe_write(REG_ADDR_LOW, first[7:0], atc_pkg::STATUS_OK, 1'b0);
         owe_write(REG_ADDR_MID, first[15:8], atc_pkg::STATUS_OK, 1'b0);
         owe_write(REG_ADDR_HIGH, first[23:16], atc_pkg::STATUS_OK, 1'b0);
      end

      // The opcode closes the request.
      if (cfg_copy.use_dma) begin
         if (mode == atc_pkg::MODE_LBA48) begin
            opcode = req.kind ? atc_pkg::OP_DMA_WRITE_EXT : atc_pkg::OP_DMA_READ_EXT;
         end else begin
            opcode = req.kind ? atc_pkg::OP_DMA_WRITE : atc_pkg::OP_DMA_READ;
         end
      end else begin
         if (mode == atc_pkg::MODE_LBA48) begin
            opcode = req.kind ? atc_pkg::OP_PIO_WRITE_EXT : atc_pkg::OP_PIO_READ_EXT;
         end else begin
            opcode = req.kind ? atc_pkg::OP_PIO_WRITE : atc_pkg::OP_PIO_READ;
         end
      end
      owe_write(atc_pkg::ATA_REG_COMMAND, opcode, atc_pkg::STATUS_OK, 1'b1);
   endfunction

   function automatic void queue_req(input logic kind,
                                     input logic [atc_pkg::LBA_W-1:0] start,
                                     input logic [atc_pkg::COUNT_W-1:0] count);
      xfer_req_type r;
      r.kind         = kind;
      r.start_sector = start;
      r.sector_count = count;
      queued_requests.push_back(r);
   endfunction

   // Writes one register and mirrors it in our copy of the settings.
   task automatic write_csr(input logic [atc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [atc_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         atc_pkg::CSR_ADDRESSING_MODE:   cfg_copy.addressing_mode = value[1:0];
         atc_pkg::CSR_CYLINDER_COUNT:    cfg_copy.cylinder_count = value[atc_pkg::CYL_W-1:0];
         atc_pkg::CSR_HEAD_COUNT:        cfg_copy.head_count = value[atc_pkg::HEADS_W-1:0];
         atc_pkg::CSR_SECTORS_PER_TRACK: cfg_copy.sectors_per_track =
                                            value[atc_pkg::SPT_W-1:0];
         atc_pkg::CSR_MAX_LBA28:         cfg_copy.max_lba28 = value[atc_pkg::MAX28_W-1:0];
         atc_pkg::CSR_MAX_LBA48:         cfg_copy.max_lba48 = value[atc_pkg::LBA_W-1:0];
         atc_pkg::CSR_DRIVE_SELECT:      cfg_copy.drive_select = value[0];
         atc_pkg::CSR_USE_DMA:           cfg_copy.use_dma = value[0];
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Waits until every request has gone in and every owed write has come out.
   task automatic drain();
      do @(negedge clock);
      while (queued_requests.size() != 0 || push || pending_writes.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   // Request driver: presents queued requests and predicts each accepted transaction.
   always @(posedge clock) begin : request_driver
      logic slot_open;
      if (reset) begin
         push <= 1'b0;
      end else begin
         slot_open = !push;
         if (push && !full) begin
            derive_taskfile_writes(req_on_bus);
            slot_open = 1'b1;
         end
         if (slot_open) begin
            if (req_gap > 0) begin
               req_gap--;
               push <= 1'b0;
            end else if (queued_requests.size() != 0) begin
               req_on_bus = queued_requests.pop_front();
               req_kind         <= req_on_bus.kind;
               req_start_sector <= req_on_bus.start_sector;
               req_sector_count <= req_on_bus.sector_count;
               push <= 1'b1;
               req_gap = pick_gap(req_calm);
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each popped transaction against the oldest owed write.
   always @(posedge clock) begin : result_monitor
      atc_pkg::rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (pending_writes.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("unexpected write: offset %0d value %02h status %0d last %0b",
                           rsp_reg_offset, rsp_reg_value, rsp_status, rsp_last);
            end else begin
               want = pending_writes.pop_front();
               if (rsp_reg_offset !== want.reg_offset || rsp_reg_value !== want.reg_value ||
                   rsp_status !== want.status || rsp_last !== want.last) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $display("write mismatch: expected offset %0d value %02h status %0d last %0b",
                              want.reg_offset, want.reg_value, want.status, want.last);
                     $display("                got offset %0d value %02h status %0d last %0b",
                              rsp_reg_offset, rsp_reg_value, rsp_status, rsp_last);
                  end
               end
            end
            rsp_stall = pick_gap(rsp_calm);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus: directed settings and requests first, then random phases.
   initial begin : stimulus
      logic [63:0]                 wide, start, reach;
      logic [atc_pkg::COUNT_W-1:0] count;
      logic [1:0]                  mode;
      logic [atc_pkg::CYL_W-1:0]   cyls;
      logic [atc_pkg::HEADS_W-1:0] heads;
      logic [atc_pkg::SPT_W-1:0]   spt;
      logic [atc_pkg::MAX28_W-1:0] max28;
      logic [atc_pkg::LBA_W-1:0]   max48;
      int                          phase_idx, item_idx;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Settings after reset: the LBA28 limit of zero rejects everything, count first.
      queue_req(XFER_READ, 48'd0, 16'd1);
      queue_req(XFER_WRITE, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
      drain();

      // LBA28 with DMA: full range, selector reuse, zero count, bounds and count limits.
      write_csr(atc_pkg::CSR_MAX_LBA28, 48'h0FFF_FFFF);
      queue_req(XFER_READ, 48'd0, 16'd1);
      queue_req(XFER_WRITE, 48'd0, 16'd0);
      queue_req(XFER_READ, 48'h0FFF_FE00, 16'd255);
      queue_req(XFER_WRITE, 48'h0FFF_FF00, 16'd255);
      queue_req(XFER_READ, 48'd0, 16'd256);
      drain();

      // LBA48 with PIO on the slave drive, right at the top of the address space.
      write_csr(atc_pkg::CSR_ADDRESSING_MODE, 48'(atc_pkg::MODE_LBA48));
      write_csr(atc_pkg::CSR_MAX_LBA48, 48'hFFFF_FFFF_FFFF);
      write_csr(atc_pkg::CSR_USE_DMA, 48'd0);
      write_csr(atc_pkg::CSR_DRIVE_SELECT, 48'd1);
      queue_req(XFER_READ, 48'hFFFF_FFFF_0000, 16'hFFFE);
      queue_req(XFER_WRITE, 48'hFFFF_FFFF_0000, 16'hFFFF);
      queue_req(XFER_WRITE, 48'h1234_5678_9ABC, 16'h8001);
      drain();

      // The reserved addressing mode is refused.
      write_csr(atc_pkg::CSR_ADDRESSING_MODE, 48'(atc_pkg::MODE_RESERVED));
      queue_req(XFER_READ, 48'd5, 16'd1);
      drain();

      // CHS with DMA is refused before the count is looked at.
      write_csr(atc_pkg::CSR_ADDRESSING_MODE, 48'(atc_pkg::MODE_CHS));
      write_csr(atc_pkg::CSR_USE_DMA, 48'd1);
      write_csr(atc_pkg::CSR_DRIVE_SELECT, 48'd0);
      queue_req(XFER_READ, 48'd0, 16'd300);
      drain();

      // CHS with PIO on the usual geometry, at and past the last cylinder.
      write_csr(atc_pkg::CSR_USE_DMA, 48'd0);
      write_csr(atc_pkg::CSR_CYLINDER_COUNT, 48'd1024);
      write_csr(atc_pkg::CSR_HEAD_COUNT, 48'd16);
      write_csr(atc_pkg::CSR_SECTORS_PER_TRACK, 48'd63);
      queue_req(XFER_READ, 48'd0, 16'd1);
      queue_req(XFER_WRITE, 48'd1031936, 16'd255);
      queue_req(XFER_READ, 48'd1031937, 16'd255);
      queue_req(XFER_READ, 48'd0, 16'd256);
      drain();

      // More than sixteen heads: only the low head bits reach the selector.
      write_csr(atc_pkg::CSR_CYLINDER_COUNT, 48'd65535);
      write_csr(atc_pkg::CSR_HEAD_COUNT, 48'd31);
      write_csr(atc_pkg::CSR_SECTORS_PER_TRACK, 48'd1);
      queue_req(XFER_READ, 48'd20, 16'd3);
      queue_req(XFER_WRITE, 48'd2031584, 16'd0);
      drain();

      // A geometry of zero heads or zero sectors per track is out of range.
      write_csr(atc_pkg::CSR_HEAD_COUNT, 48'd0);
      queue_req(XFER_READ, 48'd0, 16'd1);
      drain();
      write_csr(atc_pkg::CSR_HEAD_COUNT, 48'd1);
      write_csr(atc_pkg::CSR_SECTORS_PER_TRACK, 48'd0);
      queue_req(XFER_READ, 48'd0, 16'd1);
      drain();

      // The smallest geometry: one cylinder of one sector.
      write_csr(atc_pkg::CSR_SECTORS_PER_TRACK, 48'd1);
      write_csr(atc_pkg::CSR_CYLINDER_COUNT, 48'd1);
      queue_req(XFER_WRITE, 48'd0, 16'd0);
      queue_req(XFER_READ, 48'd0, 16'd1);
      drain();

      // Random phases: fresh settings each time, mostly requests inside the limits.
      for (phase_idx = 0; phase_idx < 8; phase_idx++) begin
         item_idx = $urandom_range(0, 15);
         if (item_idx == 0) mode = atc_pkg::MODE_RESERVED;
         else if (item_idx < 6) mode = atc_pkg::MODE_CHS;
         else if (item_idx < 11) mode = atc_pkg::MODE_LBA28;
         else mode = atc_pkg::MODE_LBA48;
         case ($urandom_range(0, 3))
            0: cyls = 16'd1;
            1: cyls = 16'hFFFF;
            default: cyls = 16'($urandom_range(1, 65535));
         endcase
         case ($urandom_range(0, 7))
            0: heads = 5'd1;
            1: heads = 5'd16;
            2: heads = 5'($urandom_range(17, 31));
            default: heads = 5'($urandom_range(1, 16));
         endcase
         case ($urandom_range(0, 3))
            0: spt = 6'd1;
            1: spt = 6'd63;
            default: spt = 6'($urandom_range(1, 63));
         endcase
         wide = {$urandom, $urandom};
         case ($urandom_range(0, 3))
            0: max28 = 28'hFFF_FFFF;
            1: max28 = 28'($urandom_range(0, 600));
            default: max28 = wide[27:0];
         endcase
         case ($urandom_range(0, 3))
            0: max48 = 48'hFFFF_FFFF_FFFF;
            1: max48 = 48'($urandom_range(0, 600));
            default: max48 = wide[63:16] >> $urandom_range(0, 40);
         endcase
         write_csr(atc_pkg::CSR_ADDRESSING_MODE, 48'(mode));
         write_csr(atc_pkg::CSR_CYLINDER_COUNT, 48'(cyls));
         write_csr(atc_pkg::CSR_HEAD_COUNT, 48'(heads));
         write_csr(atc_pkg::CSR_SECTORS_PER_TRACK, 48'(spt));
         write_csr(atc_pkg::CSR_MAX_LBA28, 48'(max28));
         write_csr(atc_pkg::CSR_MAX_LBA48, max48);
         write_csr(atc_pkg::CSR_DRIVE_SELECT, 48'($urandom_range(0, 1)));
         if (mode == atc_pkg::MODE_CHS)
            write_csr(atc_pkg::CSR_USE_DMA, 48'($urandom_range(0, 5) == 0));
         else
            write_csr(atc_pkg::CSR_USE_DMA, 48'($urandom_range(0, 1)));

         // The first sector past the end of the addressable space.
         case (mode)
            atc_pkg::MODE_CHS:   reach = 64'(cyls) * 64'(heads) * 64'(spt);
            atc_pkg::MODE_LBA28: reach = 64'(max28);
            atc_pkg::MODE_LBA48: reach = 64'(max48);
            default:             reach = 64'd0;
         endcase

         for (item_idx = 0; item_idx < 20; item_idx++) begin
            wide = {$urandom, $urandom};
            if ($urandom_range(0, 9) == 0) begin
               // Noise: any direction, sector and count.
               queue_req(1'($urandom_range(0, 1)), wide[47:0], 16'($urandom_range(0, 65535)));
            end else begin
               if (mode == atc_pkg::MODE_LBA48 && $urandom_range(0, 2) == 0)
                  count = 16'($urandom_range(256, 65535));
               else if ($urandom_range(0, 15) == 0)
                  count = 16'd0;
               else
                  count = 16'($urandom_range(1, 255));
               // Usually well inside the limit, sometimes straddling it.
               if (reach > 64'(count) + 64'd1 && $urandom_range(0, 4) != 0)
                  start = wide % (reach - 64'(count));
               else if (reach >= 64'(count) + 64'd1)
                  start = reach - 64'(count) - 64'd1 + 64'($urandom_range(0, 2));
               else
                  start = wide;
               queue_req(1'($urandom_range(0, 1)), start[47:0], count);
            end
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (error_count == 0 && pending_writes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
